FILE: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Field widths, function codes, result kinds, status codes and the character
// codes that the line editor recognizes and echoes.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Payload field widths.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;

  // Request codes on the input channel.
  localparam logic [FuncW-1:0] FUNC_RX   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_READ = 2'd1;
  localparam logic [FuncW-1:0] FUNC_PUSH = 2'd2;

  // Result kinds on the output channel.
  localparam logic [KindW-1:0] KIND_ECHO = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA = 2'd1;
  localparam logic [KindW-1:0] KIND_STAT = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_NOLINE = 2'd1;
  localparam logic [StatusW-1:0] ST_BUSY   = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd3;

  // Character codes.
  localparam logic [ByteW-1:0] CH_ERASE = 8'h7F;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_BS    = 8'h08;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_MASK  = 8'h7F;

endpackage

FILE: hdl/cle_if.sv
// ----------------------------------------------------------------------------
// Console line editor channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------

// Request channel: one word is a request code and a byte.
interface cle_in_if import cle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FuncW-1:0]   func;
  logic [ByteW-1:0]   data;

  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

// Result channel: one word is an echo, a delivered byte or a status.
interface cle_out_if import cle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   value;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, output kind, output value, output status, output last,
                  input ready);
  modport sink   (input valid, input kind, input value, input status, input last,
                  output ready);
endinterface

FILE: hdl/cle_line_mem.sv
// ----------------------------------------------------------------------------
// Console line editor line store
// Synchronous byte memory with one write port and one read port; the read
// data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module cle_line_mem import cle_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// Console line editor
// Edits received bytes into a line buffer with echo, and lets a reader drain
// completed lines byte by byte or push bytes back to the front.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_i (func, data) and results leave on out_o
// (kind, value, status, last); a word moves when valid and ready are both
// high. A request yields zero to three result words, the final one with
// last set. An erase on an empty buffer and an unused request code yield
// no word at all.
// Sequencing: the block works on one request at a time. It takes the request,
// then loads one result word per cycle into the output register while that
// register is empty or its word is being taken. A read first passes through a
// wait state for the registered read of the line memory. The first result
// word is loaded from the emit state, after that wait state for a read.
// Stalls: the output register is a single stage; while the receiver holds
// ready low, no further word is loaded and in_i stays blocked once the
// current request's words are pending. A new request is accepted while the
// final word of the previous one still waits in the output register.
// Reset: clears the fill count, front position and line-ready flag; the
// line memory needs no clearing, since only written entries are delivered.
// ----------------------------------------------------------------------------
module console_line_editor_unit import cle_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cle_in_if.sink           in_i,
  cle_out_if.source        out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [CW-1:0] FillFull = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DepthS   = SW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    P_BUSY,
    P_ERASE,
    P_FULL,
    P_CRLF,
    P_ECHO,
    P_NOLINE,
    P_READ,
    P_PUSHOK
  } plan_e;

  state_e           state_q;
  plan_e            plan_q, plan_d;
  logic [1:0]       step_q;
  logic [ByteW-1:0] byte_q;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             ready_line_q, ready_line_d;
  logic             has_result;

  logic             out_valid_q;
  logic [KindW-1:0] out_kind_q;
  logic [ByteW-1:0] out_value_q;
  logic [StatusW-1:0] out_status_q;
  logic             out_last_q;

  logic             accept;
  logic             load;
  logic [ByteW-1:0] rx_byte;
  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail_idx;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    front_inc;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ByteW-1:0] mem_wdata;
  logic             mem_re;
  logic [ByteW-1:0] mem_rdata;

  logic [KindW-1:0]   nx_kind;
  logic [ByteW-1:0]   nx_value;
  logic [StatusW-1:0] nx_status;
  logic               nx_last;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign rx_byte    = in_i.data & CH_MASK;

  // Buffer positions: tail for appends, one before front for push back.
  assign tail_sum  = SW'(front_q) + SW'(fill_q);
  assign tail_idx  = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AW'(1);

  // Request decode: state update, memory access and result plan.
  always_comb begin
    plan_d       = P_BUSY;
    has_result   = 1'b0;
    front_d      = front_q;
    fill_d       = fill_q;
    ready_line_d = ready_line_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_idx;
    mem_wdata    = rx_byte;
    mem_re       = 1'b0;
    if (accept) begin
      unique case (in_i.func)
        FUNC_RX: begin
          has_result = 1'b1;
          if (ready_line_q) begin
            plan_d = P_BUSY;
          end else if (rx_byte == CH_ERASE) begin
            if (fill_q == '0) begin
              has_result = 1'b0;
            end else begin
              plan_d = P_ERASE;
              fill_d = fill_q - CW'(1);
            end
          end else if (fill_q >= FillFull) begin
            plan_d       = P_FULL;
            ready_line_d = 1'b1;
          end else begin
            plan_d = (rx_byte == CH_CR) ? P_CRLF : P_ECHO;
            mem_we = 1'b1;
            fill_d = fill_q + CW'(1);
            if (rx_byte == CH_CR || fill_q == FillFull - CW'(1)) begin
              ready_line_d = 1'b1;
            end
          end
        end
        FUNC_READ: begin
          has_result = 1'b1;
          if (!ready_line_q || fill_q == '0) begin
            plan_d       = P_NOLINE;
            ready_line_d = 1'b0;
          end else begin
            plan_d  = P_READ;
            mem_re  = 1'b1;
            front_d = front_inc;
            fill_d  = fill_q - CW'(1);
            if (fill_q == CW'(1)) begin
              ready_line_d = 1'b0;
            end
          end
        end
        FUNC_PUSH: begin
          has_result = 1'b1;
          if (fill_q >= FillFull) begin
            plan_d = P_FULL;
          end else begin
            plan_d       = P_PUSHOK;
            mem_we       = 1'b1;
            mem_waddr    = front_dec;
            mem_wdata    = in_i.data;
            front_d      = front_dec;
            fill_d       = fill_q + CW'(1);
            ready_line_d = 1'b1;
          end
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

  cle_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (front_q),
    .rdata_o (mem_rdata)
  );

  // Next result word from the plan and the step within it.
  always_comb begin
    nx_kind   = KIND_STAT;
    nx_value  = '0;
    nx_status = ST_OK;
    nx_last   = 1'b1;
    unique case (plan_q)
      P_BUSY:   nx_status = ST_BUSY;
      P_FULL:   nx_status = ST_FULL;
      P_NOLINE: nx_status = ST_NOLINE;
      P_PUSHOK: nx_status = ST_OK;
      P_ERASE: begin
        nx_kind  = KIND_ECHO;
        nx_value = (step_q == 2'd1) ? CH_SPACE : CH_BS;
        nx_last  = (step_q == 2'd2);
      end
      P_CRLF: begin
        nx_kind  = KIND_ECHO;
        nx_value = (step_q == 2'd0) ? CH_CR : CH_LF;
        nx_last  = (step_q == 2'd1);
      end
      P_ECHO: begin
        nx_kind  = KIND_ECHO;
        nx_value = byte_q;
      end
      P_READ: begin
        nx_kind  = KIND_DATA;
        nx_value = mem_rdata;
      end
      default: ;
    endcase
  end

  assign load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // Sequencer, buffer state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      plan_q       <= P_BUSY;
      step_q       <= '0;
      front_q      <= '0;
      fill_q       <= '0;
      ready_line_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_STAT;
      out_value_q  <= '0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      front_q      <= front_d;
      fill_q       <= fill_d;
      ready_line_q <= ready_line_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept && has_result) begin
            plan_q  <= plan_d;
            step_q  <= '0;
            state_q <= (plan_d == P_READ) ? S_RDWAIT : S_EMIT;
          end
        end
        S_RDWAIT: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            step_q <= step_q + 2'd1;
            if (nx_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (load) begin
        out_valid_q  <= 1'b1;
        out_kind_q   <= nx_kind;
        out_value_q  <= nx_value;
        out_status_q <= nx_status;
        out_last_q   <= nx_last;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Echo byte kept for the result of a plain received byte.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;
  assign out_o.last   = out_last_q;

`ifndef ASSERT_OFF
  // The fill count never exceeds the buffer depth.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count above depth");

  // A line marked ready always holds at least one byte.
  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_line_q |-> (fill_q != '0))
    else $error("line ready with empty buffer");

  // The memory is never written and read in the same cycle.
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line memory read and write overlap");

  // A read that delivers a byte passes through the wait state for the memory, then emits.
  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDWAIT) |-> $past(mem_re) ##1 (state_q == S_EMIT))
    else $error("read wait sequencing broken");

  // The front position stays inside the buffer.
  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LastIdx)
    else $error("front position out of range");
`endif

endmodule

FILE: dv/console_line_editor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console line editor testbench
// Feeds typed lines, erases, reads and push-backs to the line editor through
// its request channel, and checks every result word against a predicted line
// buffer. Both channels idle at random in two of three phases; in the last,
// the result side holds off once for a long stretch so that the editor stalls.
// ----------------------------------------------------------------------------
module console_line_editor_unit_tb import cle_pkg::*; ();

  localparam int unsigned          DEPTH        = 16;
  localparam int                   RANDOM_ITEMS = 230;
  localparam int                   LONG_HOLD    = 80;
  localparam logic [FuncW-1:0]     FUNC_UNUSED  = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   value;
    logic [StatusW-1:0] status;
    logic               last;
  } result_word_t;

  // Predicts the echo, delivery and status words of the line editor and keeps
  // them in order until the result channel hands them over.
  class line_echo_predictor;
    logic [ByteW-1:0] line_mem [DEPTH];
    int unsigned      head;
    int unsigned      fill;
    bit               line_rdy;
    int               mismatches;
    result_word_t     expected_words [$];
    result_word_t     fresh [$];

    function new();
      head       = 0;
      fill       = 0;
      line_rdy   = 1'b0;
      mismatches = 0;
    endfunction

    function void add_word(logic [KindW-1:0] k, logic [ByteW-1:0] v, logic [StatusW-1:0] s);
      result_word_t w;
      w.kind   = k;
      w.value  = v;
      w.status = s;
      w.last   = 1'b0;
      fresh.insert(fresh.size(), w);
    endfunction

    // Applies one accepted request and returns the number of words it causes.
    function int note_request(logic [FuncW-1:0] f, logic [ByteW-1:0] d);
      logic [ByteW-1:0] ch;
      ch = d & CH_MASK;
      fresh.delete();
      case (f)
        FUNC_RX: begin
          if (line_rdy) begin
            add_word(KIND_STAT, '0, ST_BUSY);
          end else if (ch == CH_ERASE) begin
            // Erasing on an empty line does nothing at all.
            if (fill != 0) begin
              add_word(KIND_ECHO, CH_BS, ST_OK);
              add_word(KIND_ECHO, CH_SPACE, ST_OK);
              add_word(KIND_ECHO, CH_BS, ST_OK);
              fill--;
            end
          end else if (fill >= DEPTH) begin
            line_rdy = 1'b1;
            add_word(KIND_STAT, '0, ST_FULL);
          end else begin
            if (ch == CH_CR) begin
              add_word(KIND_ECHO, CH_CR, ST_OK);
              add_word(KIND_ECHO, CH_LF, ST_OK);
            end else begin
              add_word(KIND_ECHO, ch, ST_OK);
            end
            line_mem[(head + fill) % DEPTH] = ch;
            fill++;
            if (ch == CH_CR || fill >= DEPTH) line_rdy = 1'b1;
          end
        end
        FUNC_READ: begin
          if (!line_rdy || fill == 0) begin
            line_rdy = 1'b0;
            add_word(KIND_STAT, '0, ST_NOLINE);
          end else begin
            add_word(KIND_DATA, line_mem[head], ST_OK);
            head = (head + 1) % DEPTH;
            fill--;
            if (fill == 0) line_rdy = 1'b0;
          end
        end
        FUNC_PUSH: begin
          if (fill >= DEPTH) begin
            add_word(KIND_STAT, '0, ST_FULL);
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            line_mem[head] = d;
            fill++;
            line_rdy = 1'b1;
            add_word(KIND_STAT, '0, ST_OK);
          end
        end
        default: ;
      endcase
      if (fresh.size() > 0) begin
        fresh[fresh.size() - 1].last = 1'b1;
      end
      foreach (fresh[i]) expected_words.insert(expected_words.size(), fresh[i]);
      return fresh.size();
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_result(logic [KindW-1:0] k, logic [ByteW-1:0] v,
                               logic [StatusW-1:0] s, logic l);
      result_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: kind %0d value 0x%02h status %0d last %0b",
               k, v, s, l);
        mismatches++;
        return;
      end
      want = expected_words[0];
      expected_words.delete(0);
      if (k !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
        mismatches++;
      end
      if (v !== want.value) begin
        $error("value mismatch: expected 0x%02h, actual 0x%02h", want.value, v);
        mismatches++;
      end
      if (s !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, s);
        mismatches++;
      end
      if (l !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cle_in_if  in_if ();
  cle_out_if out_if ();

  line_echo_predictor sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  bit hold_request;

  console_line_editor_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock and the single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = FUNC_RX;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    hold_request  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result side: random ready, with one long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every word moved on the result channel is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.kind, out_if.value, out_if.status, out_if.last);
    end
  end

  // Offers one request word, starting and ending at a falling edge.
  task automatic send_request(input logic [FuncW-1:0] f, input logic [ByteW-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.data  <= d;
    do @(posedge clk_i); while (!in_if.ready);
    void'(sb.note_request(f, d));
    items_sent++;
    @(negedge clk_i);
  endtask

  // Reads a completed line out, with stray typing and push-backs mixed in.
  task automatic drain_line();
    int r;
    if (sb.fill == DEPTH && $urandom_range(0, 1) == 1) begin
      send_request(FUNC_PUSH, 8'($urandom_range(0, 255)));
    end
    while (sb.line_rdy) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_request(FUNC_RX, 8'($urandom_range(0, 255)));
      else if (r < 10) send_request(FUNC_PUSH, 8'($urandom_range(0, 255)));
      else send_request(FUNC_READ, 8'($urandom_range(0, 255)));
    end
    // One more read finds no line.
    send_request(FUNC_READ, 8'($urandom_range(0, 255)));
  endtask

  // Types a line with occasional erases, stray reads and push-backs, ends it
  // with a carriage return unless it is already complete, and drains it.
  task automatic type_line();
    int len;
    int r;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8);
    for (int i = 0; i < len && !sb.line_rdy; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_request(FUNC_RX, CH_ERASE | {$urandom_range(0, 1) == 1, 7'd0});
      else if (r < 13) send_request(FUNC_READ, 8'($urandom_range(0, 255)));
      else if (r < 15) send_request(FUNC_PUSH, 8'($urandom_range(0, 255)));
      else send_request(FUNC_RX, 8'($urandom_range(0, 255)));
    end
    if (!sb.line_rdy) begin
      send_request(FUNC_RX, CH_CR | {$urandom_range(0, 1) == 1, 7'd0});
    end
    drain_line();
  endtask

  // Stimulus and end of the run.
  initial begin
    int r;
    int k;
    @(posedge rst_ni);
    @(negedge clk_i);
    send_idle_pct = 24;
    recv_idle_pct = 86;

    // Directed: empty cases, masking, erase, carriage return, busy,
    // push-back of a full 8-bit byte, draining to empty, unused code.
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_RX, 8'hFF);
    send_request(FUNC_UNUSED, 8'hAA);
    send_request(FUNC_RX, 8'hC1);
    send_request(FUNC_RX, 8'h00);
    send_request(FUNC_RX, 8'h7E);
    send_request(FUNC_RX, CH_ERASE);
    send_request(FUNC_RX, 8'h8D);
    send_request(FUNC_RX, 8'h55);
    send_request(FUNC_READ, 8'hFF);
    send_request(FUNC_PUSH, 8'hFF);
    send_request(FUNC_PUSH, 8'h00);
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_READ, 8'h00);
    send_request(FUNC_PUSH, 8'h7F);
    send_request(FUNC_RX, CH_CR);
    send_request(FUNC_READ, 8'h00);

    // Random: mostly whole lines, some push-back runs, some noise.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 2 * RANDOM_ITEMS / 3 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end else if (items_sent >= RANDOM_ITEMS / 3 && send_idle_pct == 24) begin
        send_idle_pct = 86;
        recv_idle_pct = 24;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        type_line();
      end else if (r < 80) begin
        k = $urandom_range(1, 4);
        repeat (k) send_request(FUNC_PUSH, 8'($urandom_range(0, 255)));
        drain_line();
      end else begin
        send_request(FuncW'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    in_if.valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("** console_line_editor_unit: PASSED **");
    end else begin
      $display("** console_line_editor_unit: FAILED **");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("** console_line_editor_unit: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hdl/cle_pkg.sv
hdl/cle_if.sv
hdl/cle_line_mem.sv
hdl/console_line_editor_unit.sv
dv/console_line_editor_unit_tb.sv
